[design/crcdfr_pkg.sv]
// ----------------------------------------------------------------------------
// crcdfr_pkg
// Shared types, codes and the byte-wide CRC16 update for the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package crcdfr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 1024;
    localparam int unsigned ADDR_W          = 4;
    localparam int unsigned DATA_W          = 32;

    localparam logic [7:0]  SOF_BYTE        = 8'hAC;
    localparam logic [7:0]  EOF_BYTE        = 8'hBB;

    localparam logic [10:0] MAX_LENGTH_RST  = 11'd1024;
    localparam logic [15:0] CRC_POLY_RST    = 16'h1021;
    localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_MAX_LENGTH = 2'd0,
        REG_CRC_POLY   = 2'd1,
        REG_CRC_INIT   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_LEN_HI = 3'd1,
        ST_LEN_LO = 3'd2,
        ST_DATA   = 3'd3,
        ST_CRC_HI = 3'd4,
        ST_CRC_LO = 3'd5,
        ST_TAIL   = 3'd6
    } parse_state_t;

    typedef enum logic [2:0] {
        RES_RUN   = 3'd0,
        RES_DONE  = 3'd1,
        RES_LEN   = 3'd2,
        RES_CRC   = 3'd3,
        RES_START = 3'd4,
        RES_END   = 3'd5
    } status_t;

    typedef struct packed {
        logic [10:0] max_length;
        logic [15:0] crc_poly;
        logic [15:0] crc_init;
    } cfg_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/crcdfr_cfg.sv]
// ----------------------------------------------------------------------------
// crcdfr_cfg
// APB register file: payload length limit, CRC polynomial and CRC seed.
// ----------------------------------------------------------------------------
`default_nettype none

module crcdfr_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [crcdfr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [crcdfr_pkg::DATA_W-1:0]     pwdata,
    output logic      [crcdfr_pkg::DATA_W-1:0]     prdata,
    output logic                                   pready,
    output crcdfr_pkg::cfg_t                       cfg
);
    import crcdfr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MAX_LENGTH: cfg_next.max_length = pwdata[10:0];
                REG_CRC_POLY:   cfg_next.crc_poly   = pwdata[15:0];
                REG_CRC_INIT:   cfg_next.crc_init   = pwdata[15:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_LENGTH: prdata = {21'd0, cfg_reg.max_length};
            REG_CRC_POLY:   prdata = {16'd0, cfg_reg.crc_poly};
            REG_CRC_INIT:   prdata = {16'd0, cfg_reg.crc_init};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length <= MAX_LENGTH_RST;
            cfg_reg.crc_poly   <= CRC_POLY_RST;
            cfg_reg.crc_init   <= CRC_INIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[design/crcdfr_parser.sv]
// ----------------------------------------------------------------------------
// crcdfr_parser
// Input register, frame state machine with byte-wide CRC, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crcdfr_parser #(
    parameter int unsigned MAX_PAYLOAD = crcdfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire crcdfr_pkg::cfg_t cfg,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       rx_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [2:0]            status,
    output logic                  payload_valid,
    output logic [7:0]            payload_byte,
    output logic [9:0]            payload_offset,
    output logic [10:0]           frame_length
);
    import crcdfr_pkg::*;

    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         advance;
    logic         in_accept;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic [15:0]  length_reg;
    logic [15:0]  length_next;
    logic [10:0]  count_reg;
    logic [10:0]  count_next;
    logic [15:0]  crc_reg;
    logic [15:0]  crc_next;

    logic         out_valid_reg;
    logic         out_valid_next;
    status_t      status_reg;
    status_t      status_next;
    logic         pv_reg;
    logic         pv_next;
    logic [7:0]   pb_reg;
    logic [7:0]   pb_next;
    logic [9:0]   po_reg;
    logic [9:0]   po_next;
    logic [10:0]  fl_reg;
    logic [10:0]  fl_next;

    logic [15:0]  crc_fed;
    logic [15:0]  len_full;
    logic [10:0]  count_inc;
    logic         len_bad;

    assign advance   = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall  = in_valid_reg & ~advance;
    assign in_accept = in_valid & ~in_stall;

    assign crc_fed   = crc_feed(crc_reg, in_byte_reg, cfg.crc_poly);
    assign len_full  = {length_reg[15:8], in_byte_reg};
    assign count_inc = count_reg + 11'd1;
    assign len_bad   = (len_full == 16'd0) || (len_full > MaxLen)
                       || (len_full > {5'd0, cfg.max_length});

    // next state
    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        if (advance)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    count_next  = '0;
                    length_next = '0;
                    if (in_byte_reg == SOF_BYTE)
                    begin
                        state_next = ST_LEN_HI;
                        crc_next   = cfg.crc_init;
                    end
                end
                ST_LEN_HI:
                begin
                    length_next = {in_byte_reg, 8'd0};
                    crc_next    = crc_fed;
                    state_next  = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    length_next = len_full;
                    crc_next    = crc_fed;
                    count_next  = '0;
                    state_next  = len_bad ? ST_HUNT : ST_DATA;
                end
                ST_DATA:
                begin
                    count_next = count_inc;
                    crc_next   = crc_fed;
                    if ({5'd0, count_inc} >= length_reg)
                    begin
                        state_next = ST_CRC_HI;
                    end
                end
                ST_CRC_HI:
                begin
                    state_next = (in_byte_reg != crc_reg[15:8]) ? ST_HUNT : ST_CRC_LO;
                end
                ST_CRC_LO:
                begin
                    state_next = (in_byte_reg != crc_reg[7:0]) ? ST_HUNT : ST_TAIL;
                end
                ST_TAIL:
                begin
                    state_next = ST_HUNT;
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        status_next = RES_RUN;
        pv_next     = 1'b0;
        pb_next     = '0;
        po_next     = '0;
        fl_next     = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_byte_reg != SOF_BYTE)
                begin
                    status_next = RES_START;
                end
            end
            ST_LEN_LO:
            begin
                if (len_bad)
                begin
                    status_next = RES_LEN;
                end
            end
            ST_DATA:
            begin
                pv_next = 1'b1;
                pb_next = in_byte_reg;
                po_next = count_reg[9:0];
            end
            ST_CRC_HI:
            begin
                if (in_byte_reg != crc_reg[15:8])
                begin
                    status_next = RES_CRC;
                end
            end
            ST_CRC_LO:
            begin
                if (in_byte_reg != crc_reg[7:0])
                begin
                    status_next = RES_CRC;
                end
            end
            ST_TAIL:
            begin
                if (in_byte_reg == EOF_BYTE)
                begin
                    status_next = RES_DONE;
                    fl_next     = length_reg[10:0];
                end
                else
                begin
                    status_next = RES_END;
                end
            end
            default:
            begin
                status_next = RES_RUN;
            end
        endcase
    end

    always_comb
    begin
        priority if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_HUNT;
            length_reg    <= '0;
            count_reg     <= '0;
            crc_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            status_reg <= status_next;
            pv_reg     <= pv_next;
            pb_reg     <= pb_next;
            po_reg     <= po_next;
            fl_reg     <= fl_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign payload_valid  = pv_reg;
    assign payload_byte   = pb_reg;
    assign payload_offset = po_reg;
    assign frame_length   = fl_reg;

`ifndef SYNTHESIS
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost a pending request");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DATA |-> length_reg != 16'd0 && length_reg <= MaxLen
                                 && {5'd0, count_reg} < length_reg)
        else $error("payload count outside accepted length");

    a_payload_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pv_reg |-> status_reg == RES_RUN)
        else $error("payload byte with non-running status");

    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg == ST_TAIL |=> state_reg == ST_HUNT)
        else $error("parser did not return to hunt after tail byte");
`endif

endmodule

`default_nettype wire

[design/crc16_packet_deframer_core.sv]
// ----------------------------------------------------------------------------
// crc16_packet_deframer_core
// Byte-serial parser for length-prefixed frames with CRC16 check.
// ----------------------------------------------------------------------------
// Input channel: one received byte per request on rx_byte (in_valid/in_stall).
// Output channel: one result per input byte (out_valid/out_stall) carrying
//   status, payload_valid, payload_byte, payload_offset and frame_length.
// Frame: 0xAC, length high, length low, payload, CRC high, CRC low, 0xBB.
// Configuration: APB registers max_length (0x0), crc_poly (0x4), crc_init
//   (0x8); write only while no request is in flight.
// Path: an accepted byte waits in the input register until the result
//   register is free or being taken, then its result is registered there.
// Throughput: one byte per cycle unless results stall; a whole byte's CRC
//   update is done in the single stage between input and result register.
// Reset: parser hunts for a start byte, configuration registers take their
//   reset values, no request is held.
// Stall: a stalled result holds; the next byte still enters the input
//   register, and in_stall rises only while both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_deframer_core #(
    parameter int unsigned MAX_PAYLOAD = crcdfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [crcdfr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [crcdfr_pkg::DATA_W-1:0]     pwdata,
    output logic      [crcdfr_pkg::DATA_W-1:0]     prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [2:0]                             status,
    output logic                                   payload_valid,
    output logic [7:0]                             payload_byte,
    output logic [9:0]                             payload_offset,
    output logic [10:0]                            frame_length
);
    import crcdfr_pkg::*;

    cfg_t cfg;

    crcdfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcdfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .payload_offset (payload_offset),
        .frame_length   (frame_length)
    );

endmodule

`default_nettype wire

[test/crc16_packet_deframer_core_test.sv]
// ----------------------------------------------------------------------------
// crc16_packet_deframer_core_test
// Drives byte requests into the frame deframer and checks every result
// against a cycle-free predictor of the parser, its CRC and its registers,
// or against the pinned results of a short table. The table covers the
// framing errors and one good frame; random traffic of mostly well-formed
// frames follows under several register settings, with random gaps on the
// byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import crcdfr_pkg::*;

    localparam int unsigned FRAME_MAX        = MAX_PAYLOAD_DEF;
    localparam int unsigned RANDOM_PER_PHASE = 180;
    localparam int unsigned PHASE_COUNT      = 6;
    localparam int unsigned IDLE_LIMIT       = 4000;
    localparam int unsigned SETTLE_CYCLES    = 8;

    typedef struct packed {
        status_t     status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_offset;
        logic [10:0] frame_length;
    } deframe_result_t;

    typedef enum logic [2:0] {
        BK_LIT,
        BK_CRC_HI,
        BK_CRC_LO,
        BK_CRC_HI_BAD,
        BK_CRC_LO_BAD
    } byte_kind_t;

    typedef enum logic [1:0] {
        FF_NONE,
        FF_CRC_HI,
        FF_CRC_LO,
        FF_END
    } frame_fault_t;

    typedef struct packed {
        byte_kind_t      kind;
        logic [7:0]      value;
        logic            pinned;
        deframe_result_t want;
    } directed_row_t;

    localparam deframe_result_t NO_RES    = '0;
    localparam deframe_result_t RUN_RES   = '{RES_RUN, 1'b0, 8'h00, 10'd0, 11'd0};
    localparam deframe_result_t START_RES = '{RES_START, 1'b0, 8'h00, 10'd0, 11'd0};
    localparam deframe_result_t LEN_RES   = '{RES_LEN, 1'b0, 8'h00, 10'd0, 11'd0};
    localparam deframe_result_t CRC_RES   = '{RES_CRC, 1'b0, 8'h00, 10'd0, 11'd0};
    localparam deframe_result_t END_RES   = '{RES_END, 1'b0, 8'h00, 10'd0, 11'd0};
    localparam deframe_result_t DONE2_RES = '{RES_DONE, 1'b0, 8'h00, 10'd0, 11'd2};

    localparam directed_row_t DIRECTED_ROWS [27] = '{
        '{BK_LIT,        8'h00, 1'b1, START_RES},
        '{BK_LIT,        8'hAC, 1'b1, RUN_RES},
        '{BK_LIT,        8'h00, 1'b1, RUN_RES},
        '{BK_LIT,        8'h00, 1'b1, LEN_RES},
        '{BK_LIT,        8'hAC, 1'b1, RUN_RES},
        '{BK_LIT,        8'h04, 1'b1, RUN_RES},
        '{BK_LIT,        8'h01, 1'b1, LEN_RES},
        '{BK_LIT,        8'hAC, 1'b0, NO_RES},
        '{BK_LIT,        8'h00, 1'b0, NO_RES},
        '{BK_LIT,        8'h02, 1'b0, NO_RES},
        '{BK_LIT,        8'h00, 1'b0, NO_RES},
        '{BK_LIT,        8'hFF, 1'b0, NO_RES},
        '{BK_CRC_HI,     8'h00, 1'b0, NO_RES},
        '{BK_CRC_LO,     8'h00, 1'b0, NO_RES},
        '{BK_LIT,        8'hBB, 1'b1, DONE2_RES},
        '{BK_LIT,        8'hAC, 1'b0, NO_RES},
        '{BK_LIT,        8'h00, 1'b0, NO_RES},
        '{BK_LIT,        8'h01, 1'b0, NO_RES},
        '{BK_LIT,        8'hA5, 1'b0, NO_RES},
        '{BK_CRC_HI_BAD, 8'h00, 1'b1, CRC_RES},
        '{BK_LIT,        8'hAC, 1'b0, NO_RES},
        '{BK_LIT,        8'h00, 1'b0, NO_RES},
        '{BK_LIT,        8'h01, 1'b0, NO_RES},
        '{BK_LIT,        8'h5A, 1'b0, NO_RES},
        '{BK_CRC_HI,     8'h00, 1'b0, NO_RES},
        '{BK_CRC_LO,     8'h00, 1'b0, NO_RES},
        '{BK_LIT,        8'h00, 1'b1, END_RES}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          rx_byte;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          status;
    logic                payload_valid;
    logic [7:0]          payload_byte;
    logic [9:0]          payload_offset;
    logic [10:0]         frame_length;

    cfg_t                active_cfg;
    parse_state_t        frame_state;
    logic [15:0]         rx_length;
    logic [10:0]         rx_count;
    logic [15:0]         run_crc;

    deframe_result_t     pending_results[$];
    int unsigned         items_sent;
    int unsigned         error_count;
    bit                  in_burst;
    bit                  out_burst;

    crc16_packet_deframer_core #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .payload_valid(payload_valid),
        .payload_byte(payload_byte),
        .payload_offset(payload_offset),
        .frame_length(frame_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
        logic [15:0] r;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[15] ^ b[i])
            begin
                r = {r[14:0], 1'b0} ^ poly;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic deframe_result_t deframe_predict(input logic [7:0] b);
        deframe_result_t r;
        r = '0;
        r.status = RES_RUN;
        case (frame_state)
            ST_HUNT:
            begin
                rx_count = '0;
                rx_length = '0;
                if (b == SOF_BYTE)
                begin
                    frame_state = ST_LEN_HI;
                    run_crc = active_cfg.crc_init;
                end
                else
                begin
                    r.status = RES_START;
                end
            end
            ST_LEN_HI:
            begin
                rx_length = {b, 8'h00};
                run_crc = crc16_step(run_crc, b, active_cfg.crc_poly);
                frame_state = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                rx_length = rx_length + 16'(b);
                run_crc = crc16_step(run_crc, b, active_cfg.crc_poly);
                rx_count = '0;
                if (rx_length == 16'd0 || rx_length > FRAME_MAX ||
                    rx_length > 16'(active_cfg.max_length))
                begin
                    frame_state = ST_HUNT;
                    r.status = RES_LEN;
                end
                else
                begin
                    frame_state = ST_DATA;
                end
            end
            ST_DATA:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte = b;
                r.payload_offset = rx_count[9:0];
                rx_count = rx_count + 11'd1;
                run_crc = crc16_step(run_crc, b, active_cfg.crc_poly);
                if (16'(rx_count) >= rx_length)
                begin
                    frame_state = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                if (b != run_crc[15:8])
                begin
                    frame_state = ST_HUNT;
                    r.status = RES_CRC;
                end
                else
                begin
                    frame_state = ST_CRC_LO;
                end
            end
            ST_CRC_LO:
            begin
                if (b != run_crc[7:0])
                begin
                    frame_state = ST_HUNT;
                    r.status = RES_CRC;
                end
                else
                begin
                    frame_state = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                frame_state = ST_HUNT;
                if (b == EOF_BYTE)
                begin
                    r.status = RES_DONE;
                    r.frame_length = rx_length[10:0];
                end
                else
                begin
                    r.status = RES_END;
                end
            end
            default:
            begin
                frame_state = ST_HUNT;
            end
        endcase
        return r;
    endfunction

    function automatic int unsigned draw_wait(input bit burst);
        if (burst)
        begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [15:0] pick_length();
        int unsigned cap;
        int unsigned sel;
        cap = active_cfg.max_length;
        sel = $urandom_range(0, 9);
        if (sel == 0 && cap <= 64)
        begin
            return 16'(cap);
        end
        if (sel < 7)
        begin
            return 16'($urandom_range(1, cap < 8 ? cap : 8));
        end
        return 16'($urandom_range(1, cap < 48 ? cap : 48));
    endfunction

    task automatic send_req(input byte_kind_t kind, input logic [7:0] value,
                            input logic pinned, input deframe_result_t want);
        logic [7:0]      b;
        deframe_result_t predicted;
        int unsigned     gap;
        case (kind)
            BK_CRC_HI:     b = run_crc[15:8];
            BK_CRC_LO:     b = run_crc[7:0];
            BK_CRC_HI_BAD: b = run_crc[15:8] ^ 8'($urandom_range(1, 255));
            BK_CRC_LO_BAD: b = run_crc[7:0] ^ 8'($urandom_range(1, 255));
            default:       b = value;
        endcase
        predicted = deframe_predict(b);
        if (items_sent % 48 == 0)
        begin
            in_burst = ($urandom_range(0, 3) == 0);
        end
        gap = draw_wait(in_burst);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(pinned ? want : predicted);
        items_sent++;
    endtask

    task automatic send_byte(input byte_kind_t kind, input logic [7:0] value);
        send_req(kind, value, 1'b0, NO_RES);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_MAX_LENGTH: active_cfg.max_length = value[10:0];
            REG_CRC_POLY:   active_cfg.crc_poly = value[15:0];
            REG_CRC_INIT:   active_cfg.crc_init = value[15:0];
            default:        ;
        endcase
    endtask

    task automatic send_frame(input logic [15:0] len, input frame_fault_t fault);
        logic [7:0] tail;
        send_byte(BK_LIT, SOF_BYTE);
        send_byte(BK_LIT, len[15:8]);
        send_byte(BK_LIT, len[7:0]);
        if (frame_state != ST_DATA)
        begin
            return;
        end
        for (int i = 0; i < int'(len); i++)
        begin
            send_byte(BK_LIT, 8'($urandom));
        end
        send_byte(fault == FF_CRC_HI ? BK_CRC_HI_BAD : BK_CRC_HI, 8'h00);
        if (fault == FF_CRC_HI)
        begin
            return;
        end
        send_byte(fault == FF_CRC_LO ? BK_CRC_LO_BAD : BK_CRC_LO, 8'h00);
        if (fault == FF_CRC_LO)
        begin
            return;
        end
        tail = EOF_BYTE;
        if (fault == FF_END)
        begin
            tail = 8'($urandom);
            if (tail == EOF_BYTE)
            begin
                tail = ~tail;
            end
        end
        send_byte(BK_LIT, tail);
    endtask

    task automatic gen_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        logic [15:0] len;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_frame(pick_length(), FF_NONE);
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 2))
                    0:       len = 16'd0;
                    1:       len = 16'(active_cfg.max_length) + 16'd1;
                    default: len = 16'($urandom_range(FRAME_MAX + 1, 65535));
                endcase
                send_frame(len, FF_NONE);
            end
            else if (pick < 84)
            begin
                send_frame(pick_length(), FF_CRC_HI);
            end
            else if (pick < 90)
            begin
                send_frame(pick_length(), FF_CRC_LO);
            end
            else if (pick < 95)
            begin
                send_frame(pick_length(), FF_END);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_byte(BK_LIT, 8'($urandom));
            end
            if ($urandom_range(0, 49) == 0)
            begin
                release_input();
                drain();
            end
        end
    endtask

    initial
    begin : result_stall
        int unsigned hold;
        int unsigned taken;
        out_stall = 1'b0;
        out_burst = 1'b0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 40 == 0)
            begin
                out_burst = ($urandom_range(0, 3) == 0);
            end
            hold = draw_wait(out_burst);
            if (hold != 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin : result_check
        deframe_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d", status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (payload_valid !== want.payload_valid)
                begin
                    $error("payload_valid: expected %0d, got %0d",
                           want.payload_valid, payload_valid);
                    error_count++;
                end
                if (payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h",
                           want.payload_byte, payload_byte);
                    error_count++;
                end
                if (payload_offset !== want.payload_offset)
                begin
                    $error("payload_offset: expected %0d, got %0d",
                           want.payload_offset, payload_offset);
                    error_count++;
                end
                if (frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, frame_length);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("crc16_packet_deframer_core_test failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        items_sent = 0;
        error_count = 0;
        in_burst = 1'b0;
        active_cfg.max_length = MAX_LENGTH_RST;
        active_cfg.crc_poly = CRC_POLY_RST;
        active_cfg.crc_init = CRC_INIT_RST;
        frame_state = ST_HUNT;
        rx_length = '0;
        rx_count = '0;
        run_crc = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            send_req(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value,
                     DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
        end
        gen_traffic(RANDOM_PER_PHASE);

        for (int phase = 1; phase < PHASE_COUNT; phase++)
        begin
            release_input();
            drain();
            case (phase)
                1:
                begin
                    write_reg(REG_MAX_LENGTH, 32'd1);
                    write_reg(REG_CRC_POLY, 32'h0000);
                    write_reg(REG_CRC_INIT, 32'h0000);
                end
                2:
                begin
                    write_reg(REG_MAX_LENGTH, 32'd1024);
                    write_reg(REG_CRC_POLY, 32'hFFFF);
                    write_reg(REG_CRC_INIT, 32'hFFFF);
                end
                3:
                begin
                    write_reg(REG_MAX_LENGTH, 32'($urandom_range(2, 64)));
                    write_reg(REG_CRC_POLY, 32'($urandom_range(0, 65535)));
                    write_reg(REG_CRC_INIT, 32'($urandom_range(0, 65535)));
                end
                default:
                begin
                    write_reg(REG_MAX_LENGTH, 32'($urandom_range(1, 1024)));
                    write_reg(REG_CRC_POLY, 32'($urandom_range(0, 65535)));
                    write_reg(REG_CRC_INIT, 32'($urandom_range(0, 65535)));
                end
            endcase
            gen_traffic(RANDOM_PER_PHASE);
        end

        release_input();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("crc16_packet_deframer_core_test passed");
        end
        else
        begin
            $display("crc16_packet_deframer_core_test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/crcdfr_pkg.sv
design/crcdfr_cfg.sv
design/crcdfr_parser.sv
design/crc16_packet_deframer_core.sv
test/crc16_packet_deframer_core_test.sv
